// ===== src/delta_list_task_scheduler_assert.svh =====
// Assertion helpers shared by the scheduler RTL.
`ifndef DELTA_LIST_TASK_SCHEDULER_ASSERT_SVH
`define DELTA_LIST_TASK_SCHEDULER_ASSERT_SVH

// Condition in a cycle implies a consequence in the same cycle.
`define DLTS_ASSERT_SAME(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// Condition in a cycle implies a consequence in the next cycle.
`define DLTS_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== src/dlts_pkg.sv =====
package dlts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int TAG_BITS      = 16;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_DISP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NONE      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_NOP  = 2'd0,
    OP_TICK = 2'd1,
    OP_INS  = 2'd2,
    OP_REM  = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] task_tag;
    logic [31:0] first_delay;
    logic [31:0] repeat_period;
    logic [31:0] target_id;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] given_id;
    logic        run_now;
    logic [15:0] run_tag;
  } out_t;

  typedef struct packed {
    logic                valid;
    logic [TAG_BITS-1:0] tag;
    logic [31:0]         delta;
    logic [31:0]         period;
    logic                ready;
    logic [31:0]         id;
  } entry_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    cell_op_t    op;
    entry_t      ent;
    logic        adj_en;
    logic [31:0] adj_delta;
  } ctl_t;

endpackage

// ===== src/dlts_cell.sv =====
module dlts_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  dlts_pkg::ctl_t  ctl,
  input  logic            at,
  input  logic            after,
  input  logic            adj,
  input  dlts_pkg::entry_t prev_i,
  input  dlts_pkg::entry_t next_i,
  output dlts_pkg::entry_t q
);

  dlts_pkg::entry_t q_r;
  dlts_pkg::entry_t q_nxt;
  logic [32:0]      fold_sum;

  assign fold_sum = {1'b0, next_i.delta} + {1'b0, q_r.delta};

  always_comb begin
    q_nxt = q_r;
    unique case (ctl.op)
      dlts_pkg::OP_TICK: begin
        if (at && q_r.valid && !q_r.ready) begin
          if (q_r.delta != 32'd0) q_nxt.delta = q_r.delta - 32'd1;
          q_nxt.ready = (q_nxt.delta == 32'd0);
        end
      end
      dlts_pkg::OP_INS: begin
        if (at) begin
          q_nxt = ctl.ent;
        end else if (after) begin
          q_nxt = prev_i;
          if (adj && ctl.adj_en) q_nxt.delta = ctl.adj_delta;
        end
      end
      dlts_pkg::OP_REM: begin
        if (at || after) begin
          q_nxt = next_i;
          // fold the removed delta into its successor, saturating
          if (at && next_i.valid) q_nxt.delta = fold_sum[32] ? 32'hFFFF_FFFF : fold_sum[31:0];
        end
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== src/delta_list_task_scheduler.sv =====
// Delta-list task scheduler: a row of MAX_TASKS entry cells kept sorted by due time, each
// holding its delay relative to the entry ahead of it. Tick, one-shot dispatch, and dispatch
// or add/delete with an immediate answer (full table, target id 0, nothing ready), show their
// result in the cycle after the input transfer. Add walks the row one entry a cycle through a
// single sequencer adder, past at most MAX_TASKS-1 entries ahead of the insertion point.
// Delete searches one entry a cycle and answers once it finds a match, or after the last slot
// when nothing matches. Dispatch of a periodic task removes the head in the transfer cycle and
// then walks like an add. Insertions and removals shift the whole row at once.
// One command is in work at a time; the result register frees the input for the next one.
module delta_list_task_scheduler #(
  parameter int MAX_TASKS = dlts_pkg::MAX_TASKS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dlts_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dlts_pkg::out_t out_data
);

`include "delta_list_task_scheduler_assert.svh"

  localparam int IW = $clog2(MAX_TASKS);

  typedef enum logic [1:0] {S_IDLE, S_ADD, S_DEL} state_t;

  state_t st_r, st_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [dlts_pkg::TAG_BITS-1:0] jtag_r, jtag_nxt;
  logic [31:0] jdelay_r, jdelay_nxt;
  logic [31:0] jper_r, jper_nxt;
  logic [31:0] jtarget_r, jtarget_nxt;
  logic jrun_r, jrun_nxt;
  logic [31:0] id_cnt_r, id_cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  dlts_pkg::out_t out_data_r, out_data_nxt;

  dlts_pkg::ctl_t ctl;
  logic [IW-1:0] pos;
  dlts_pkg::entry_t cells_q [MAX_TASKS];
  dlts_pkg::entry_t cur;
  logic [MAX_TASKS-1:0] vld_vec;
  logic [MAX_TASKS-1:0] at_v, after_v, adj_v;
  logic accept;
  logic [31:0] nid, lead_delta;
  logic [32:0] newsum, rest;

  assign in_ready = (st_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign cur      = cells_q[idx_r];

  always_comb begin
    nid = id_cnt_r + 32'd1;
    if (nid == 32'd0) nid = 32'd1;
  end

  assign lead_delta = jdelay_r - sum_r;
  assign newsum     = {1'b0, sum_r} + {1'b0, cur.delta};
  assign rest       = newsum - {1'b0, jdelay_r};

  always_comb begin
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    jtag_nxt      = jtag_r;
    jdelay_nxt    = jdelay_r;
    jper_nxt      = jper_r;
    jtarget_nxt   = jtarget_r;
    jrun_nxt      = jrun_r;
    id_cnt_nxt    = id_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    ctl.op        = dlts_pkg::OP_NOP;
    pos           = '0;
    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          out_data_nxt = '0;
          unique case (dlts_pkg::cmd_t'(in_data.command))
            dlts_pkg::CMD_TICK: begin
              ctl.op        = dlts_pkg::OP_TICK;
              out_valid_nxt = 1'b1;
            end
            dlts_pkg::CMD_ADD: begin
              if (cells_q[MAX_TASKS-1].valid) begin
                out_data_nxt.status = dlts_pkg::ST_FULL;
                out_valid_nxt       = 1'b1;
              end else begin
                jtag_nxt   = in_data.task_tag[dlts_pkg::TAG_BITS-1:0];
                jdelay_nxt = in_data.first_delay;
                jper_nxt   = in_data.repeat_period;
                jrun_nxt   = 1'b0;
                idx_nxt    = '0;
                sum_nxt    = '0;
                st_nxt     = S_ADD;
              end
            end
            dlts_pkg::CMD_DEL: begin
              if (in_data.target_id == 32'd0) begin
                out_data_nxt.status = dlts_pkg::ST_NOT_FOUND;
                out_valid_nxt       = 1'b1;
              end else begin
                jtarget_nxt = in_data.target_id;
                idx_nxt     = '0;
                st_nxt      = S_DEL;
              end
            end
            default: begin
              if (cells_q[0].valid && cells_q[0].ready) begin
                ctl.op = dlts_pkg::OP_REM;
                if (cells_q[0].period != 32'd0) begin
                  // re-add after the removal has landed
                  jtag_nxt   = cells_q[0].tag;
                  jdelay_nxt = cells_q[0].period;
                  jper_nxt   = cells_q[0].period;
                  jrun_nxt   = 1'b1;
                  idx_nxt    = '0;
                  sum_nxt    = '0;
                  st_nxt     = S_ADD;
                end else begin
                  out_data_nxt.run_now = 1'b1;
                  out_data_nxt.run_tag = cells_q[0].tag;
                  out_valid_nxt        = 1'b1;
                end
              end else begin
                out_data_nxt.status = dlts_pkg::ST_NONE;
                out_valid_nxt       = 1'b1;
              end
            end
          endcase
        end
      end
      S_ADD: begin
        if (!cur.valid || (newsum > {1'b0, jdelay_r})) begin
          pos              = idx_r;
          ctl.op           = dlts_pkg::OP_INS;
          ctl.ent.valid    = 1'b1;
          ctl.ent.tag      = jtag_r;
          ctl.ent.delta    = lead_delta;
          ctl.ent.period   = jper_r;
          ctl.ent.ready    = (lead_delta == 32'd0);
          ctl.ent.id       = nid;
          ctl.adj_en       = cur.valid;
          ctl.adj_delta    = rest[32] ? 32'hFFFF_FFFF : rest[31:0];
          id_cnt_nxt       = nid;
          out_data_nxt.status   = dlts_pkg::ST_OK;
          out_data_nxt.given_id = nid;
          out_data_nxt.run_now  = jrun_r;
          out_data_nxt.run_tag  = jrun_r ? jtag_r : '0;
          out_valid_nxt    = 1'b1;
          st_nxt           = S_IDLE;
        end else begin
          sum_nxt = newsum[31:0];
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DEL: begin
        if (cur.valid && (cur.id == jtarget_r)) begin
          pos                 = idx_r;
          ctl.op              = dlts_pkg::OP_REM;
          out_data_nxt.status = dlts_pkg::ST_OK;
          out_valid_nxt       = 1'b1;
          st_nxt              = S_IDLE;
        end else if (idx_r == IW'(MAX_TASKS - 1)) begin
          out_data_nxt.status = dlts_pkg::ST_NOT_FOUND;
          out_valid_nxt       = 1'b1;
          st_nxt              = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      id_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      id_cnt_r    <= id_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    sum_r      <= sum_nxt;
    jtag_r     <= jtag_nxt;
    jdelay_r   <= jdelay_nxt;
    jper_r     <= jper_nxt;
    jtarget_r  <= jtarget_nxt;
    jrun_r     <= jrun_nxt;
    out_data_r <= out_data_nxt;
  end

  for (genvar j = 0; j < MAX_TASKS; j++) begin : g_cell
    dlts_pkg::entry_t prev_e, next_e;
    assign at_v[j]    = (pos == IW'(j));
    assign after_v[j] = ({1'b0, pos} < (IW+1)'(j));
    assign adj_v[j]   = (({1'b0, pos} + (IW+1)'(1)) == (IW+1)'(j));
    assign vld_vec[j] = cells_q[j].valid;
    if (j == 0) begin : g_first
      assign prev_e = '0;
    end else begin : g_mid
      assign prev_e = cells_q[j-1];
    end
    if (j == MAX_TASKS - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = cells_q[j+1];
    end
    dlts_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .at     (at_v[j]),
      .after  (after_v[j]),
      .adj    (adj_v[j]),
      .prev_i (prev_e),
      .next_i (next_e),
      .q      (cells_q[j])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `DLTS_ASSERT_SAME(a_packed_row, clk, rst_n, 1'b1, $onehot({1'b0, vld_vec} + (MAX_TASKS+1)'(1)))
  `DLTS_ASSERT_SAME(a_add_has_room, clk, rst_n, st_r == S_ADD, !vld_vec[MAX_TASKS-1])
  `DLTS_ASSERT_NEXT(a_id_nonzero, clk, rst_n, ctl.op == dlts_pkg::OP_INS, id_cnt_r != 32'd0)
  `DLTS_ASSERT_SAME(a_out_source, clk, rst_n, $rose(out_valid_r), $past(accept) || $past(st_r != S_IDLE))

endmodule
